FILE: hdl/sbf_pkg.sv
// Shared types and constants for the spring / bungee force unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sbf_pkg;

    // spring constant and rest length register width
    localparam int KW = 31;

    localparam logic [2:0] CFG_SPRING_K  = 3'd0;
    localparam logic [2:0] CFG_REST_LEN  = 3'd1;
    localparam logic [2:0] CFG_BUNGEE    = 3'd2;
    localparam logic [2:0] CFG_USE_ANCH  = 3'd3;
    localparam logic [2:0] CFG_ANCHOR_X  = 3'd4;
    localparam logic [2:0] CFG_ANCHOR_Y  = 3'd5;
    localparam logic [2:0] CFG_ANCHOR_Z  = 3'd6;

    // per-component control riding along the divider
    typedef struct packed {
        logic neg;   // displacement below zero
        logic nz;    // displacement nonzero
        logic ovf;   // quotient beyond coordinate range
        logic idle;  // no force for this word
    } sbf_tag_t;

endpackage
`default_nettype wire

FILE: hdl/spring_bungee_force_unit.sv
// Top level of the spring / bungee force unit: config registers and pipeline.
// Depends on sbf_pkg, sbf_sqrt and sbf_div.
//
//  channel  | dir | content (low bits first)
//  s_       | in  | pos_x, pos_y, pos_z, end_x, end_y, end_z
//  m_       | out | tdata: force_x, force_y, force_z; tuser: no_force, saturated
//  cfg_     | in  | write enable, register index, write data
//
// One word per cycle enters and leaves while m_tready allows it; the square
// root stages produce one root bit each and the divider stages one quotient
// bit each. All stages advance together and hold
// while a result waits on m_tready. Reset clears the valid bits and the
// config registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module spring_bungee_force_unit
    import sbf_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // pos_x, pos_y, pos_z, end_x, end_y, end_z
    input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // force_x, force_y, force_z
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]         m_tdata,
    // no_force, saturated
    output logic [1:0]                                 m_tuser,
    input  wire logic                                  cfg_we,
    input  wire logic [2:0]                            cfg_addr,
    input  wire logic [(COORD_WIDTH > KW ? COORD_WIDTH : KW)-1:0] cfg_wdata
);
    localparam int W      = COORD_WIDTH;
    localparam int DW     = W + 1;
    localparam int AW     = W + 1;
    localparam int SQW    = 2 * AW;
    localparam int SW     = SQW + 2;
    localparam int LW     = SW / 2;
    localparam int MW     = (LW > KW) ? LW : KW;
    localparam int PW     = KW + MW;
    localparam int MAGW   = PW - FRAC_BITS;
    localparam int LOH    = MAGW / 2;
    localparam int HIW    = MAGW - LOH;
    localparam int NW     = MAGW + AW;
    localparam int SIDE_W = 3 * AW + 6;
    localparam int ODW    = ((3 * W + 7) / 8) * 8;

    logic [KW-1:0] spring_k_reg;
    logic [KW-1:0] rest_len_reg;
    logic          bungee_reg;
    logic          use_anchor_reg;
    logic [W-1:0]  anchor_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spring_k_reg   <= KW'(65536);
            rest_len_reg   <= KW'(65536);
            bungee_reg     <= 1'b0;
            use_anchor_reg <= 1'b0;
            anchor_reg[0]  <= '0;
            anchor_reg[1]  <= '0;
            anchor_reg[2]  <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SPRING_K: spring_k_reg   <= cfg_wdata[KW-1:0];
                CFG_REST_LEN: rest_len_reg   <= cfg_wdata[KW-1:0];
                CFG_BUNGEE:   bungee_reg     <= cfg_wdata[0];
                CFG_USE_ANCH: use_anchor_reg <= cfg_wdata[0];
                CFG_ANCHOR_X: anchor_reg[0]  <= cfg_wdata[W-1:0];
                CFG_ANCHOR_Y: anchor_reg[1]  <= cfg_wdata[W-1:0];
                CFG_ANCHOR_Z: anchor_reg[2]  <= cfg_wdata[W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // stage 1: displacement
    logic          v1_reg;
    logic [DW-1:0] d1_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic [W-1:0] p;
                logic [W-1:0] e;
                p = s_tdata[k*W +: W];
                e = use_anchor_reg ? anchor_reg[k] : s_tdata[(k+3)*W +: W];
                d1_reg[k] <= {p[W-1], p} - {e[W-1], e};
            end
        end
    end

    // stage 2: magnitude and sign
    logic          v2_reg;
    logic [AW-1:0] ad2_reg [3];
    logic [2:0]    neg2_reg;
    logic [2:0]    nz2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                ad2_reg[k]  <= d1_reg[k][DW-1] ? AW'(-d1_reg[k]) : AW'(d1_reg[k]);
                neg2_reg[k] <= d1_reg[k][DW-1];
                nz2_reg[k]  <= |d1_reg[k];
            end
        end
    end

    // stage 3: squares
    logic           v3_reg;
    logic [SQW-1:0] sq3_reg [3];
    logic [AW-1:0]  ad3_reg [3];
    logic [2:0]     neg3_reg;
    logic [2:0]     nz3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                sq3_reg[k] <= ad2_reg[k] * ad2_reg[k];
                ad3_reg[k] <= ad2_reg[k];
            end
            neg3_reg <= neg2_reg;
            nz3_reg  <= nz2_reg;
        end
    end

    // stage 4: sum of squares
    logic              v4_reg;
    logic [SW-1:0]     sum4_reg;
    logic [SIDE_W-1:0] side4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum4_reg  <= SW'(sq3_reg[0]) + SW'(sq3_reg[1]) + SW'(sq3_reg[2]);
            side4_reg <= {ad3_reg[2], ad3_reg[1], ad3_reg[0], neg3_reg, nz3_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    logic              sq_valid;
    logic [LW-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side;

    sbf_sqrt #(
        .SW     (SW),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .rad       (sum4_reg),
        .in_side   (side4_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // stage 5: stretch
    logic              v5_reg;
    logic [LW-1:0]     len5_reg;
    logic [MW-1:0]     m5_reg;
    logic              idle5_reg;
    logic [SIDE_W-1:0] side5_reg;
    logic [MW-1:0]     len_x;
    logic [MW-1:0]     rest_x;

    assign len_x  = MW'(sq_root);
    assign rest_x = MW'(rest_len_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            len5_reg  <= sq_root;
            m5_reg    <= (len_x > rest_x) ? len_x - rest_x : rest_x - len_x;
            idle5_reg <= (sq_root == '0) || (bungee_reg && len_x <= rest_x);
            side5_reg <= sq_side;
        end
    end

    // stage 6: force magnitude
    logic              v6_reg;
    logic [MAGW-1:0]   mag6_reg;
    logic [LW-1:0]     len6_reg;
    logic              idle6_reg;
    logic [SIDE_W-1:0] side6_reg;
    logic [PW-1:0]     prod6;

    assign prod6 = PW'(spring_k_reg) * PW'(m5_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            mag6_reg  <= prod6[PW-1:FRAC_BITS];
            len6_reg  <= len5_reg;
            idle6_reg <= idle5_reg;
            side6_reg <= side5_reg;
        end
    end

    // stage 7: partial products of magnitude times component
    logic              v7_reg;
    logic [LOH+AW-1:0] pl7_reg [3];
    logic [HIW+AW-1:0] ph7_reg [3];
    logic [LW-1:0]     len7_reg;
    logic              idle7_reg;
    logic [5:0]        flag7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pl7_reg[k] <= (LOH+AW)'(mag6_reg[LOH-1:0]) *
                              (LOH+AW)'(side6_reg[6+k*AW +: AW]);
                ph7_reg[k] <= (HIW+AW)'(mag6_reg[MAGW-1:LOH]) *
                              (HIW+AW)'(side6_reg[6+k*AW +: AW]);
            end
            len7_reg  <= len6_reg;
            idle7_reg <= idle6_reg;
            flag7_reg <= side6_reg[5:0];
        end
    end

    // stage 8: numerators
    logic          v8_reg;
    logic [NW-1:0] n8_reg [3];
    logic [LW-1:0] len8_reg;
    logic          idle8_reg;
    logic [5:0]    flag8_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                n8_reg[k] <= NW'(pl7_reg[k]) + (NW'(ph7_reg[k]) << LOH);
            end
            len8_reg  <= len7_reg;
            idle8_reg <= idle7_reg;
            flag8_reg <= flag7_reg;
        end
    end

    // stage 9: range check ahead of the dividers
    logic          v9_reg;
    logic [LW-1:0] rem9_reg [3];
    logic [W-1:0]  lo9_reg  [3];
    logic [LW-1:0] len9_reg;
    sbf_tag_t      tag9_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                rem9_reg[k]      <= n8_reg[k][W +: LW];
                lo9_reg[k]       <= n8_reg[k][W-1:0];
                tag9_reg[k].neg  <= flag8_reg[3+k];
                tag9_reg[k].nz   <= flag8_reg[k];
                tag9_reg[k].ovf  <= n8_reg[k][NW-1:W] >= (NW-W)'(len8_reg);
                tag9_reg[k].idle <= idle8_reg;
            end
            len9_reg <= len8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= sq_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    logic         dv_valid [3];
    logic [W-1:0] dv_quot  [3];
    sbf_tag_t     dv_tag   [3];

    for (genvar gk = 0; gk < 3; gk++) begin : g_div
        sbf_div #(
            .QW (W),
            .LW (LW)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v9_reg),
            .rem0      (rem9_reg[gk]),
            .num_lo    (lo9_reg[gk]),
            .den       (len9_reg),
            .in_tag    (tag9_reg[gk]),
            .out_valid (dv_valid[gk]),
            .quot      (dv_quot[gk]),
            .out_tag   (dv_tag[gk])
        );
    end

    // output stage: clip, apply direction
    logic [W-1:0] force_reg [3];
    logic         no_force_reg;
    logic         sat_reg;
    logic [W-1:0] force_next [3];
    logic [2:0]   clip_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [W-1:0] limit;
            logic [W-1:0] qs;
            limit = dv_tag[k].neg ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
            clip_next[k] = dv_tag[k].nz && !dv_tag[k].idle &&
                           (dv_tag[k].ovf || dv_quot[k] > limit);
            qs = clip_next[k] ? limit : dv_quot[k];
            if (!dv_tag[k].nz || dv_tag[k].idle) begin
                force_next[k] = '0;
            end else begin
                force_next[k] = dv_tag[k].neg ? qs : W'(-qs);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_valid[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            force_reg[0] <= force_next[0];
            force_reg[1] <= force_next[1];
            force_reg[2] <= force_next[2];
            no_force_reg <= dv_tag[0].idle;
            sat_reg      <= |clip_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ODW'({force_reg[2], force_reg[1], force_reg[0]});
    assign m_tuser  = {sat_reg, no_force_reg};

endmodule
`default_nettype wire

FILE: hdl/sbf_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on nothing; carries a side vector alongside each word.
`timescale 1ns / 1ps
`default_nettype none
module sbf_sqrt #(
    parameter int SW     = 68,
    parameter int SIDE_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [SW-1:0]     rad,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [SW/2-1:0]        root,
    output logic [SIDE_W-1:0]      out_side
);
    localparam int LW = SW / 2;

    logic              v_reg    [LW];
    logic [LW:0]       rem_reg  [LW];
    logic [LW-1:0]     root_reg [LW];
    logic [SW-1:0]     rad_reg  [LW];
    logic [SIDE_W-1:0] side_reg [LW];

    for (genvar gi = 0; gi < LW; gi++) begin : g_step
        logic              v_src;
        logic [LW:0]       rem_src;
        logic [LW-1:0]     root_src;
        logic [SW-1:0]     rad_src;
        logic [SIDE_W-1:0] side_src;
        logic [LW+2:0]     rem_sh;
        logic [LW+2:0]     trial;
        logic              take;

        if (gi == 0) begin : g_first
            assign v_src    = in_valid;
            assign rem_src  = '0;
            assign root_src = '0;
            assign rad_src  = rad;
            assign side_src = in_side;
        end else begin : g_next
            assign v_src    = v_reg[gi-1];
            assign rem_src  = rem_reg[gi-1];
            assign root_src = root_reg[gi-1];
            assign rad_src  = rad_reg[gi-1];
            assign side_src = side_reg[gi-1];
        end

        assign rem_sh = {rem_src, rad_src[SW-1:SW-2]};
        assign trial  = (LW+3)'({root_src, 2'b01});
        assign take   = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[gi] <= 1'b0;
            end else if (en) begin
                v_reg[gi] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[gi]  <= take ? (LW+1)'(rem_sh - trial) : (LW+1)'(rem_sh);
                root_reg[gi] <= {root_src[LW-2:0], take};
                rad_reg[gi]  <= {rad_src[SW-3:0], 2'b00};
                side_reg[gi] <= side_src;
            end
        end
    end

    assign out_valid = v_reg[LW-1];
    assign root      = root_reg[LW-1];
    assign out_side  = side_reg[LW-1];

endmodule
`default_nettype wire

FILE: hdl/sbf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on sbf_pkg for the per-component tag.
`timescale 1ns / 1ps
`default_nettype none
module sbf_div
    import sbf_pkg::*;
#(
    parameter int QW = 32,
    parameter int LW = 34
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [LW-1:0] rem0,
    input  wire logic [QW-1:0] num_lo,
    input  wire logic [LW-1:0] den,
    input  wire sbf_tag_t      in_tag,
    output logic               out_valid,
    output logic [QW-1:0]      quot,
    output sbf_tag_t           out_tag
);
    logic          v_reg   [QW];
    logic [LW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [LW-1:0] den_reg [QW];
    sbf_tag_t      tag_reg [QW];

    for (genvar gi = 0; gi < QW; gi++) begin : g_step
        logic          v_src;
        logic [LW-1:0] rem_src;
        logic [QW-1:0] low_src;
        logic [QW-1:0] q_src;
        logic [LW-1:0] den_src;
        sbf_tag_t      tag_src;
        logic [LW:0]   rem_sh;
        logic          ge;

        if (gi == 0) begin : g_first
            assign v_src   = in_valid;
            assign rem_src = rem0;
            assign low_src = num_lo;
            assign q_src   = '0;
            assign den_src = den;
            assign tag_src = in_tag;
        end else begin : g_next
            assign v_src   = v_reg[gi-1];
            assign rem_src = rem_reg[gi-1];
            assign low_src = low_reg[gi-1];
            assign q_src   = q_reg[gi-1];
            assign den_src = den_reg[gi-1];
            assign tag_src = tag_reg[gi-1];
        end

        assign rem_sh = {rem_src, low_src[QW-1]};
        assign ge     = rem_sh >= {1'b0, den_src};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[gi] <= 1'b0;
            end else if (en) begin
                v_reg[gi] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[gi] <= ge ? LW'(rem_sh - {1'b0, den_src}) : LW'(rem_sh);
                low_reg[gi] <= {low_src[QW-2:0], 1'b0};
                q_reg[gi]   <= {q_src[QW-2:0], ge};
                den_reg[gi] <= den_src;
                tag_reg[gi] <= tag_src;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule
`default_nettype wire

FILE: hdl/sbf_checker.sv
// Port-level checks for the spring / bungee force unit, bound to the top.
// Depends on spring_bungee_force_unit.
`timescale 1ns / 1ps
`default_nettype none
module sbf_checker #(
    parameter int COORD_WIDTH = 32
) (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_tready,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]   m_tdata,
    input wire logic [1:0]                           m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("nonzero force with no_force set");

    a_idle_nosat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("saturated set with no_force");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind spring_bungee_force_unit sbf_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sbf_checker (.*);
`default_nettype wire

FILE: test/spring_bungee_force_unit_test.sv
// Testbench for spring_bungee_force_unit: directed and random pairs, random stalls on both sides.
// Forces are predicted in a scoreboard class and compared word by word. Depends on sbf_pkg.
`timescale 1ns / 1ps
module spring_bungee_force_unit_test;
    import sbf_pkg::*;

    localparam int CW       = 32;
    localparam int DRAIN    = 2 * CW + 12 + 40;
    localparam int WD_LIMIT = 4000;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic [CW-1:0] pos [3];
        logic [CW-1:0] oth [3];
    } pair_t;

    typedef struct {
        logic [CW-1:0] frc [3];
        logic          idle;
        logic          sat;
    } force_t;

    class force_board;
        logic [30:0]   k_q;
        logic [30:0]   rest_q;
        logic          bungee;
        logic          anchored;
        logic [CW-1:0] anchor [3];
        force_t        pending [$];
        int            errors;

        function new();
            k_q = 31'd65536;
            rest_q = 31'd65536;
            bungee = 1'b0;
            anchored = 1'b0;
            anchor = '{default: '0};
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [CW-1:0] val);
            case (idx)
                CFG_SPRING_K: k_q = val[30:0];
                CFG_REST_LEN: rest_q = val[30:0];
                CFG_BUNGEE:   bungee = val[0];
                CFG_USE_ANCH: anchored = val[0];
                CFG_ANCHOR_X: anchor[0] = val;
                CFG_ANCHOR_Y: anchor[1] = val;
                CFG_ANCHOR_Z: anchor[2] = val;
                default: ;
            endcase
        endfunction

        function force_t spring_force(pair_t it);
            force_t r;
            longint d [3];
            logic [127:0] ad [3];
            logic [127:0] sum, root, c, len, stretch, mag, q, limit;
            r.frc = '{default: '0};
            r.idle = 1'b0;
            r.sat = 1'b0;
            sum = '0;
            for (int i = 0; i < 3; i++) begin
                d[i] = longint'($signed(it.pos[i])) -
                       longint'($signed(anchored ? anchor[i] : it.oth[i]));
                ad[i] = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
                sum += ad[i] * ad[i];
            end
            root = '0;
            for (int b = 63; b >= 0; b--) begin
                c = root | (128'd1 << b);
                if (c * c <= sum) root = c;
            end
            len = root;
            if (len == 0 || (bungee && len <= 128'(rest_q))) begin
                r.idle = 1'b1;
                return r;
            end
            stretch = (len > 128'(rest_q)) ? len - 128'(rest_q) : 128'(rest_q) - len;
            mag = (128'(k_q) * stretch) >> 16;
            for (int i = 0; i < 3; i++) begin
                if (d[i] == 0) continue;
                q = (mag * ad[i]) / len;
                limit = (d[i] > 0) ? 128'h8000_0000 : 128'h7fff_ffff;
                if (q > limit) begin
                    q = limit;
                    r.sat = 1'b1;
                end
                r.frc[i] = (d[i] > 0) ? -q[CW-1:0] : q[CW-1:0];
            end
            return r;
        endfunction

        function void note(pair_t it);
            pending.insert(pending.size(), spring_force(it));
        endfunction

        function void check(force_t got);
            force_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word fx=%h fy=%h fz=%h", $time,
                         got.frc[0], got.frc[1], got.frc[2]);
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 3; i++)
                if (got.frc[i] !== want.frc[i]) begin
                    $display("%0t: force[%0d] expected %h actual %h", $time, i,
                             want.frc[i], got.frc[i]);
                    errors++;
                end
            if (got.idle !== want.idle) begin
                $display("%0t: no_force expected %b actual %b", $time, want.idle, got.idle);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [191:0]  s_tdata;   // pos_x, pos_y, pos_z, end_x, end_y, end_z
    logic          m_tvalid;
    logic          m_tready;
    logic [95:0]   m_tdata;   // force_x, force_y, force_z
    logic [1:0]    m_tuser;   // no_force, saturated
    logic          cfg_we;
    logic [2:0]    cfg_addr;
    logic [CW-1:0] cfg_wdata;

    force_board sb;
    logic       calm;
    int         quiet;

    spring_bungee_force_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = calm ? 1'b1 : ($urandom_range(99) >= 38);
        end
    end

    always @(posedge aclk) begin
        force_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.frc[0] = m_tdata[31:0];
            got.frc[1] = m_tdata[63:32];
            got.frc[2] = m_tdata[95:64];
            got.idle = m_tuser[0];
            got.sat = m_tuser[1];
            sb.check(got);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WD_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(pair_t it);
        if (!calm)
            while ($urandom_range(99) < 38) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
        s_tvalid = 1'b1;
        s_tdata = {it.oth[2], it.oth[1], it.oth[0], it.pos[2], it.pos[1], it.pos[0]};
        do @(posedge aclk); while (!s_tready);
        sb.note(it);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [CW-1:0] val);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic setup(logic [30:0] k, logic [30:0] rest, logic bmode, logic anch,
                         logic [CW-1:0] ax, logic [CW-1:0] ay, logic [CW-1:0] az);
        settle();
        write_reg(CFG_SPRING_K, CW'(k));
        write_reg(CFG_REST_LEN, CW'(rest));
        write_reg(CFG_BUNGEE, CW'(bmode));
        write_reg(CFG_USE_ANCH, CW'(anch));
        write_reg(CFG_ANCHOR_X, ax);
        write_reg(CFG_ANCHOR_Y, ay);
        write_reg(CFG_ANCHOR_Z, az);
    endtask

    function automatic pair_t make_pair(logic [CW-1:0] px, logic [CW-1:0] py,
                                        logic [CW-1:0] pz, logic [CW-1:0] ex,
                                        logic [CW-1:0] ey, logic [CW-1:0] ez);
        pair_t it;
        it.pos = '{px, py, pz};
        it.oth = '{ex, ey, ez};
        return it;
    endfunction

    function automatic pair_t rand_pair();
        pair_t it;
        int mode;
        mode = $urandom_range(3);
        for (int i = 0; i < 3; i++) begin
            it.pos[i] = $urandom;
            case (mode)
                0: it.oth[i] = $urandom;
                1: it.oth[i] = it.pos[i] + CW'($signed($urandom_range(1 << 21) - (1 << 20)));
                2: begin
                    it.pos[i] = CW'($signed($urandom_range(1 << 19) - (1 << 18)));
                    it.oth[i] = CW'($signed($urandom_range(1 << 19) - (1 << 18)));
                end
                default: it.oth[i] = ($urandom_range(1) == 0) ? it.pos[i] :
                                     it.pos[i] + CW'($signed($urandom_range(1 << 18) - (1 << 17)));
            endcase
        end
        return it;
    endfunction

    function automatic logic [30:0] rand_k();
        case ($urandom_range(3))
            0: return 31'h7fff_ffff;
            1: return 31'($urandom_range(1 << 20));
            default: return 31'($urandom_range(1 << 17));
        endcase
    endfunction

    initial begin
        logic [CW-1:0] mx, mn;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        sb = new();
        calm = 1'b0;
        quiet = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = CFG_SPRING_K;
        cfg_wdata = '0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // defaults: zero length, extremes, compressed spring, single axes
        send(make_pair(0, 0, 0, 0, 0, 0));
        send(make_pair(mx, mx, mx, mn, mn, mn));
        send(make_pair(mn, mn, mn, mx, mx, mx));
        send(make_pair(32'h0000_8000, 0, 0, 0, 0, 0));
        send(make_pair(0, 32'h0003_0000, 0, 0, 0, 0));
        send(make_pair(0, 0, mn, 0, 0, 0));
        send(make_pair(5, 7, 9, 5, 7, 9));
        send(make_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0));
        settle();
        write_reg(CFG_UNUSED, 32'hffff_ffff);
        send(make_pair(32'h0002_0000, 32'h0001_0000, 0, 0, 0, 0));

        // bungee: slack, at rest, stretched; max stiffness to saturate
        setup(31'h7fff_ffff, 31'h0002_0000, 1'b1, 1'b0, 0, 0, 0);
        send(make_pair(32'h0001_0000, 0, 0, 0, 0, 0));
        send(make_pair(32'h0002_0000, 0, 0, 0, 0, 0));
        send(make_pair(32'h0002_0001, 0, 0, 0, 0, 0));
        send(make_pair(mx, 0, 0, mn, 0, 0));
        send(make_pair(mn, 0, 0, mx, 0, 0));
        send(make_pair(mx, mn, mx, mn, mx, mn));

        // anchored at extremes, zero stiffness and max rest
        setup(31'd0, 31'h7fff_ffff, 1'b0, 1'b1, mx, mn, 0);
        send(make_pair(0, 0, 0, 1, 2, 3));
        send(make_pair(mx, mn, 0, 0, 0, 0));
        setup(31'h0001_0000, 31'h7fff_ffff, 1'b0, 1'b1, mn, mx, mx);
        send(make_pair(mx, mn, mn, mx, mn, mn));
        send(make_pair(0, 0, 0, 0, 0, 0));
        setup(31'h0001_0000, 31'd0, 1'b1, 1'b1, 0, 0, 0);
        send(make_pair(0, 0, 0, 9, 9, 9));
        send(make_pair(32'h0000_0001, 0, 0, 0, 0, 0));

        for (int ph = 0; ph < 8; ph++) begin
            setup(rand_k(),
                  ($urandom_range(4) == 0) ? 31'($urandom) : 31'($urandom_range(1 << 19)),
                  1'($urandom_range(1)), ($urandom_range(3) == 0), $urandom,
                  CW'($signed($urandom_range(1 << 19) - (1 << 18))), $urandom);
            calm = (ph == 3);
            for (int n = 0; n < 125; n++) send(rand_pair());
            calm = 1'b0;
        end

        settle();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
